// File: hw/rtl/sshbd_pkg.sv
// shared types, constants and prefix tables for the ssh banner detector
// no dependencies; imported by every module of the block
package sshbd_pkg;

  // byte counter width and the wider of counter and limit register widths
  localparam int COUNT_BITS = 16;
  localparam int LIMIT_W    = 16;
  localparam int OUT_W      = 16;
  localparam int CMP_W      = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;
  localparam logic [LIMIT_W-1:0]    LIMIT_RESET = LIMIT_W'(1000);

  // marker and terminator bytes
  localparam logic [23:0] MARK_HEAD = 24'h535348;  // "SSH"
  localparam logic [7:0]  MARK_TAIL = 8'h2D;       // "-"
  localparam logic [7:0]  LINE_FEED = 8'h0A;
  localparam logic [2:0]  IDX_LAST  = 3'd7;

  typedef enum logic {
    PH_SEARCH,
    PH_MATCH
  } phase_t;

  typedef enum logic [1:0] {
    DEC_NONE    = 2'd0,
    DEC_MATCHED = 2'd1,
    DEC_FAILED  = 2'd2
  } dec_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED    = 2'd0,
    ST_UNSUPPORTED = 2'd1,
    ST_TOO_LONG    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    VER_1_0  = 2'd0,
    VER_1_99 = 2'd1,
    VER_2_0  = 2'd2
  } version_t;

  // one byte held in the input stage
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } beat_t;

  // one result item
  typedef struct packed {
    logic [1:0]       status;
    logic [1:0]       version;
    logic [OUT_W-1:0] banner_offset;
    logic [OUT_W-1:0] consumed;
  } result_t;

  // length of each version prefix after the marker
  function automatic logic [2:0] prefix_len(input logic [1:0] ver);
    logic [2:0] len;
    case (ver)
      VER_1_99: len = 3'd5;
      default:  len = 3'd4;
    endcase
    return len;
  endfunction

  // expected byte of each version prefix at a given position
  function automatic logic [7:0] prefix_char(input logic [1:0] ver, input logic [2:0] idx);
    logic [7:0] ch;
    case ({ver, idx})
      {VER_1_0, 3'd0}:  ch = "1";
      {VER_1_0, 3'd1}:  ch = ".";
      {VER_1_0, 3'd2}:  ch = "0";
      {VER_1_0, 3'd3}:  ch = "-";
      {VER_1_99, 3'd0}: ch = "1";
      {VER_1_99, 3'd1}: ch = ".";
      {VER_1_99, 3'd2}: ch = "9";
      {VER_1_99, 3'd3}: ch = "9";
      {VER_1_99, 3'd4}: ch = "-";
      {VER_2_0, 3'd0}:  ch = "2";
      {VER_2_0, 3'd1}:  ch = ".";
      {VER_2_0, 3'd2}:  ch = "0";
      {VER_2_0, 3'd3}:  ch = "-";
      default:          ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// File: hw/rtl/sshbd_if.sv
// valid/ready channel interfaces: byte input, result output, limit register write
// no dependencies
interface sshbd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface sshbd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  version;
  logic [15:0] banner_offset;
  logic [15:0] consumed;
  modport source (output valid, output status, output version, output banner_offset,
                  output consumed, input ready);
  modport sink (input valid, input status, input version, input banner_offset,
                input consumed, output ready);
endinterface

interface sshbd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_bytes;
  modport source (output valid, output max_bytes, input ready);
  modport sink (input valid, input max_bytes, output ready);
endinterface

// File: hw/rtl/sshbd_in_stage.sv
// input register: captures one byte beat and holds it until the matcher takes it
// depends on sshbd_pkg and sshbd_byte_if
module sshbd_in_stage
  import sshbd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  sshbd_byte_if.sink    byte_in,
  input  logic          drain,
  output beat_t         held
);

  logic       held_valid;
  logic [7:0] held_data;

  // accept when empty or when the held beat leaves this cycle
  assign byte_in.ready = !held_valid || drain;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (byte_in.valid && byte_in.ready) begin
      held_valid <= 1'b1;
    end else if (drain) begin
      held_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      held_data <= byte_in.data_byte;
    end
  end

  assign held.valid = held_valid;
  assign held.data  = held_data;

endmodule

// File: hw/rtl/sshbd_matcher.sv
// banner matcher: scan state registers and the per-byte next-state logic
// depends on sshbd_pkg
module sshbd_matcher
  import sshbd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  beat_t              held,
  input  logic               drain,
  input  logic [LIMIT_W-1:0] max_bytes,
  output logic               emit,
  output result_t            res
);

  phase_t                phase, phase_next;
  logic [23:0]           recent_bytes, recent_bytes_next;
  logic [COUNT_BITS-1:0] byte_count, byte_count_next;
  logic [COUNT_BITS-1:0] marker_offset, marker_offset_next;
  logic [2:0]            prefix_index, prefix_index_next;
  logic [2:0]            candidates_alive, candidates_alive_next;
  logic [1:0]            matched_version, matched_version_next;
  dec_t                  version_decided, version_decided_next;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [7:0]            b;

  assign b = held.data;

  // state registers, advanced once per byte beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_SEARCH;
      recent_bytes     <= '0;
      byte_count       <= '0;
      marker_offset    <= '0;
      prefix_index     <= '0;
      candidates_alive <= 3'b111;
      matched_version  <= '0;
      version_decided  <= DEC_NONE;
    end else if (drain) begin
      phase            <= phase_next;
      recent_bytes     <= recent_bytes_next;
      byte_count       <= byte_count_next;
      marker_offset    <= marker_offset_next;
      prefix_index     <= prefix_index_next;
      candidates_alive <= candidates_alive_next;
      matched_version  <= matched_version_next;
      version_decided  <= version_decided_next;
    end
  end

  // next state and result for the held byte
  always_comb begin
    cnt_inc = (byte_count == COUNT_MAX) ? byte_count : byte_count + 1'b1;

    phase_next            = phase;
    recent_bytes_next     = recent_bytes;
    byte_count_next       = cnt_inc;
    marker_offset_next    = marker_offset;
    prefix_index_next     = prefix_index;
    candidates_alive_next = candidates_alive;
    matched_version_next  = matched_version;
    version_decided_next  = version_decided;
    emit                  = 1'b0;
    res                   = '0;

    unique case (phase)
      PH_SEARCH: begin
        // look for "SSH-" in the sliding window
        if (b == MARK_TAIL && recent_bytes == MARK_HEAD) begin
          phase_next         = PH_MATCH;
          marker_offset_next = (cnt_inc >= COUNT_BITS'(4)) ? cnt_inc - COUNT_BITS'(4) : '0;
        end
        recent_bytes_next = {recent_bytes[15:0], b};
      end
      PH_MATCH: begin
        if (b == LINE_FEED) begin
          // end of banner line
          emit              = 1'b1;
          res.banner_offset = OUT_W'(CMP_W'(marker_offset));
          if (version_decided == DEC_MATCHED) begin
            res.status  = ST_ACCEPTED;
            res.version = matched_version;
          end else begin
            res.status  = ST_UNSUPPORTED;
            res.version = VER_1_0;
          end
        end else if (version_decided == DEC_NONE) begin
          // check all live prefixes in parallel
          for (int c = 0; c < 3; c++) begin
            if (candidates_alive[c]) begin
              if (prefix_index >= prefix_len(2'(c)) || b != prefix_char(2'(c), prefix_index)) begin
                candidates_alive_next[c] = 1'b0;
              end else if (prefix_index + 3'd1 == prefix_len(2'(c))) begin
                matched_version_next = 2'(c);
                version_decided_next = DEC_MATCHED;
              end
            end
          end
          if (version_decided_next == DEC_NONE && candidates_alive_next == 3'b000) begin
            version_decided_next = DEC_FAILED;
          end
          if (prefix_index < IDX_LAST) begin
            prefix_index_next = prefix_index + 3'd1;
          end
        end
      end
      default: begin
      end
    endcase

    // byte limit or saturated counter
    if (!emit && (CMP_W'(cnt_inc) >= CMP_W'(max_bytes) || cnt_inc == COUNT_MAX)) begin
      emit              = 1'b1;
      res.status        = ST_TOO_LONG;
      res.version       = VER_1_0;
      res.banner_offset = (phase_next == PH_MATCH) ? OUT_W'(CMP_W'(marker_offset_next)) : '0;
    end

    res.consumed = OUT_W'(CMP_W'(cnt_inc));

    // restart the search after any result
    if (emit) begin
      phase_next            = PH_SEARCH;
      recent_bytes_next     = '0;
      byte_count_next       = '0;
      marker_offset_next    = '0;
      prefix_index_next     = '0;
      candidates_alive_next = 3'b111;
      matched_version_next  = '0;
      version_decided_next  = DEC_NONE;
    end
  end

endmodule

// File: hw/rtl/sshbd_out_stage.sv
// result register: holds one result beat until the consumer takes it
// depends on sshbd_pkg and sshbd_result_if
module sshbd_out_stage
  import sshbd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  result_t         res,
  output logic            space,
  sshbd_result_if.source  result_out
);

  logic    out_valid;
  result_t out_data;

  // free now or freed by the consumer this cycle
  assign space = !out_valid || result_out.ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

  assign result_out.valid         = out_valid;
  assign result_out.status        = out_data.status;
  assign result_out.version       = out_data.version;
  assign result_out.banner_offset = out_data.banner_offset;
  assign result_out.consumed      = out_data.consumed;

endmodule

// File: hw/rtl/ssh_banner_detector_unit.sv
// top level of the ssh banner detector: limit register and stage wiring
// depends on sshbd_pkg, sshbd_if, sshbd_in_stage, sshbd_matcher, sshbd_out_stage
//
//  channel     | dir | payload                                      | beat
//  byte_in     | in  | data_byte[7:0]                               | valid & ready
//  result_out  | out | status[1:0] version[1:0] banner_offset[15:0] | valid & ready
//              |     | consumed[15:0]                               |
//  cfg         | in  | max_bytes[15:0]                              | valid & ready
//
// one byte per cycle sustained while result_out.ready is high; a byte is
// registered in the input register and its result, if any, is loaded into the
// result register as the byte drains; the matcher scan state advances per drain.
// synchronous reset sets the limit to 1000 and restarts the search.
// while a result waits and result_out.ready is low, the matcher holds and the
// input register fills, then byte_in.ready drops. cfg is always ready.
module ssh_banner_detector_unit
  import sshbd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  sshbd_byte_if.sink      byte_in,
  sshbd_result_if.source  result_out,
  sshbd_cfg_if.sink       cfg
);

  logic [LIMIT_W-1:0] max_bytes;
  beat_t              held;
  logic               drain;
  logic               emit;
  logic               space;
  result_t            res;

  // limit register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      max_bytes <= cfg.max_bytes;
    end
  end

  // the held byte moves on when the result register can take a result
  assign drain = held.valid && space;

  sshbd_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .drain   (drain),
    .held    (held)
  );

  sshbd_matcher u_match (
    .clk       (clk),
    .rst       (rst),
    .held      (held),
    .drain     (drain),
    .max_bytes (max_bytes),
    .emit      (emit),
    .res       (res)
  );

  sshbd_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (drain && emit),
    .res        (res),
    .space      (space),
    .result_out (result_out)
  );

endmodule
